// File: rtl/core/multidim_histogram_binner_unit_defines.svh
// Assertion macros used by the histogram binner controller.
`ifndef MULTIDIM_HISTOGRAM_BINNER_UNIT_DEFINES_SVH
`define MULTIDIM_HISTOGRAM_BINNER_UNIT_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define MHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define MHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mhb_pkg.sv
// Package with the request, result and command types of the histogram binner.
`default_nettype none
package mhb_pkg;
	localparam int unsigned CMD_W = 2;
	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_ACC = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_OOB = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;
	localparam logic [1:0] ST_BADIDX = 2'd3;

	localparam logic [2:0] REG_DIMS = 3'd0;
	localparam logic [2:0] REG_E0 = 3'd1;
	localparam logic [2:0] REG_E1 = 3'd2;
	localparam logic [2:0] REG_E2 = 3'd3;
	localparam logic [2:0] REG_E3 = 3'd4;
	localparam logic [2:0] REG_WEIGHTED = 3'd5;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] edge_index;
		logic signed [31:0] edge_value;
		logic signed [31:0] coord0;
		logic signed [31:0] coord1;
		logic signed [31:0] coord2;
		logic signed [31:0] coord3;
		logic [31:0] weight;
		logic [11:0] bin_select;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [11:0] bin_index;
		logic [31:0] bin_value;
	} res_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic load;       // capture request, reset per-item state
		logic edge_wr;    // write edge store
		logic chk_rd;     // issue edge read for bounds check (first or last)
		logic chk_last;   // last edge, for the read or the evaluation
		logic chk_eval;   // evaluate returned edge against coordinate
		logic srch_rd;    // issue scan read
		logic srch_eval;  // evaluate scanned edge
		logic dim_next;   // advance dimension (bounds phase)
		logic dim_fold;   // fold bin into flat index, advance dimension
		logic hist_rd;    // read histogram entry
		logic hist_wr;    // write histogram entry
		logic sweep_wr;   // clearing pass write
		logic res_load;   // capture result
	} cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic bad_layout;
		logic out_of_bounds;
		logic last_dim;
		logic srch_done;
		logic flat_beyond;
		logic sel_beyond;
		logic sweep_done;
	} stat_t;
endpackage
`default_nettype wire

// File: rtl/core/mhb_ctrl.sv
// Controller state machine of the histogram binner.
`default_nettype none
`include "multidim_histogram_binner_unit_defines.svh"
module mhb_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] cmd_in,
	input wire mhb_pkg::stat_t st,
	output mhb_pkg::cmd_t cm
);
	import mhb_pkg::*;

	localparam logic [3:0] S_SWEEP = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_DISPATCH = 4'd2;
	localparam logic [3:0] S_CHK_LO = 4'd3;
	localparam logic [3:0] S_CHK_HI = 4'd4;
	localparam logic [3:0] S_CHK_EV = 4'd5;
	localparam logic [3:0] S_SRCH = 4'd6;
	localparam logic [3:0] S_SRCH_EV = 4'd7;
	localparam logic [3:0] S_FOLD = 4'd8;
	localparam logic [3:0] S_HRD = 4'd9;
	localparam logic [3:0] S_HWAIT = 4'd10;
	localparam logic [3:0] S_HWR = 4'd11;
	localparam logic [3:0] S_RESULT = 4'd12;
	localparam logic [3:0] S_CHK_EV2 = 4'd13;

	logic [3:0] state_q, state_d;
	logic [1:0] cmd_q;
	logic out_valid_q;
	logic out_take;

	assign out_take = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall = !(state_q == S_IDLE) || (out_valid_q && out_stall);

	always_comb begin
		state_d = state_q;
		cm = '0;
		unique case (state_q)
			S_SWEEP: begin
				cm.sweep_wr = 1'b1;
				if (st.sweep_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cm.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (cmd_q)
					CMD_EDGE: begin
						cm.edge_wr = 1'b1;
						state_d = S_RESULT;
					end
					CMD_ACC: begin
						if (st.bad_layout) state_d = S_RESULT;
						else state_d = S_CHK_LO;
					end
					default: begin
						if (st.sel_beyond) state_d = S_RESULT;
						else state_d = S_HRD;
					end
				endcase
			end
			S_CHK_LO: begin
				cm.chk_rd = 1'b1;
				state_d = S_CHK_HI;
			end
			S_CHK_HI: begin
				cm.chk_rd = 1'b1;
				cm.chk_last = 1'b1;
				state_d = S_CHK_EV;
			end
			S_CHK_EV: begin
				cm.chk_eval = 1'b1;
				cm.chk_last = 1'b1;
				state_d = S_CHK_EV2;
			end
			S_CHK_EV2: begin
				cm.chk_eval = 1'b1;
				if (st.last_dim) state_d = S_SRCH;
				else begin
					cm.dim_next = 1'b1;
					state_d = S_CHK_LO;
				end
			end
			S_SRCH: begin
				if (st.out_of_bounds) state_d = S_RESULT;
				else if (st.srch_done) state_d = S_FOLD;
				else begin
					cm.srch_rd = 1'b1;
					state_d = S_SRCH_EV;
				end
			end
			S_SRCH_EV: begin
				cm.srch_eval = 1'b1;
				state_d = S_SRCH;
			end
			S_FOLD: begin
				cm.dim_fold = 1'b1;
				if (st.last_dim) state_d = S_HRD;
				else state_d = S_SRCH;
			end
			S_HRD: begin
				if (cmd_q == CMD_ACC && st.flat_beyond) state_d = S_RESULT;
				else begin
					cm.hist_rd = 1'b1;
					state_d = S_HWAIT;
				end
			end
			S_HWAIT: state_d = S_HWR;
			S_HWR: begin
				if (cmd_q != CMD_READ) cm.hist_wr = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				cm.res_load = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cmd_q <= CMD_EDGE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cm.load) cmd_q <= cmd_in;
			if (cm.res_load) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end

	`MHB_ASSERT_IMP(a_res_free, clk, arst_n, cm.res_load, !out_valid_q, "result overwrite")
	`MHB_ASSERT_IMP(a_load_idle, clk, arst_n, cm.load, state_q == S_IDLE, "load outside idle")
	`MHB_ASSERT_NEXT(a_res_valid, clk, arst_n, cm.res_load, out_valid_q, "result not presented")
	`MHB_ASSERT_IMP(a_no_wr_read, clk, arst_n, cm.hist_wr, cmd_q != CMD_READ, "write on read request")
endmodule
`default_nettype wire

// File: rtl/core/mhb_datapath.sv
// Datapath of the histogram binner: edge store, search, histogram store and result.
`default_nettype none
module mhb_datapath #(
	parameter int unsigned HIST_BINS = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mhb_pkg::req_t req,
	input wire mhb_pkg::cmd_t cm,
	output mhb_pkg::stat_t st,
	output mhb_pkg::res_t res,
	input wire logic [2:0] dims_cfg,
	input wire logic [6:0] e0,
	input wire logic [6:0] e1,
	input wire logic [6:0] e2,
	input wire logic [6:0] e3,
	input wire logic weighted
);
	import mhb_pkg::*;

	localparam int unsigned HB = $clog2(HIST_BINS);

	logic [31:0] edge_mem [0:255];
	logic [31:0] edge_rd_q;
	logic [31:0] hist_mem [0:HIST_BINS-1];
	logic [31:0] hist_rd_q;

	req_t req_q;
	res_t res_d;
	logic [1:0] dim_q;
	logic [1:0] last_dim;
	logic [8:0] base_q;
	logic [6:0] n_cur;
	logic [6:0] lo_q, cnt_q;
	logic oob_q;
	logic [23:0] flat_q;
	logic [HB-1:0] sweep_q;
	logic [HB-1:0] hidx;
	logic signed [31:0] coord;
	logic [7:0] ed_addr;
	logic bad;
	logic [9:0] tot;
	logic [5:0] bin;
	logic [32:0] sum;
	logic [31:0] addv, newv;

	always_comb begin
		last_dim = 2'd0;
		case (dims_cfg)
			3'd0, 3'd1: last_dim = 2'd0;
			3'd2: last_dim = 2'd1;
			3'd3: last_dim = 2'd2;
			default: last_dim = 2'd3;
		endcase
		case (dim_q)
			2'd0: begin n_cur = e0; coord = req_q.coord0; end
			2'd1: begin n_cur = e1; coord = req_q.coord1; end
			2'd2: begin n_cur = e2; coord = req_q.coord2; end
			default: begin n_cur = e3; coord = req_q.coord3; end
		endcase
		bad = 1'b0;
		if (e0 < 7'd2 || e0 > 7'd64) bad = 1'b1;
		if (last_dim >= 2'd1 && (e1 < 7'd2 || e1 > 7'd64)) bad = 1'b1;
		if (last_dim >= 2'd2 && (e2 < 7'd2 || e2 > 7'd64)) bad = 1'b1;
		if (last_dim >= 2'd3 && (e3 < 7'd2 || e3 > 7'd64)) bad = 1'b1;
		tot = {3'd0, e0} + ((last_dim >= 2'd1) ? {3'd0, e1} : 10'd0)
			+ ((last_dim >= 2'd2) ? {3'd0, e2} : 10'd0)
			+ ((last_dim >= 2'd3) ? {3'd0, e3} : 10'd0);
		if (tot > 10'd256) bad = 1'b1;
		if (cm.srch_rd) ed_addr = 8'(base_q + {2'd0, lo_q});
		else if (cm.chk_rd && cm.chk_last) ed_addr = 8'(base_q + {2'd0, n_cur} - 9'd1);
		else ed_addr = base_q[7:0];
		bin = (cnt_q == 7'd0) ? 6'd0 : 6'(cnt_q - 7'd1);
		if ({1'b0, bin} > n_cur - 7'd2) bin = 6'(n_cur - 7'd2);
		hidx = (req_q.cmd == CMD_ACC) ? flat_q[HB-1:0] : HB'(req_q.bin_select);
		addv = weighted ? req_q.weight : 32'd1;
		sum = {1'b0, hist_rd_q} + {1'b0, addv};
		newv = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	end

	assign st.bad_layout = bad;
	assign st.out_of_bounds = oob_q;
	assign st.last_dim = (dim_q == last_dim);
	assign st.srch_done = (lo_q >= n_cur);
	assign st.flat_beyond = (flat_q >= 24'(HIST_BINS));
	assign st.sel_beyond = ({20'd0, req_q.bin_select} >= 32'(HIST_BINS));
	assign st.sweep_done = (sweep_q == HB'(HIST_BINS - 1));

	always_comb begin
		res_d = '0;
		res_d.status = ST_DONE;
		if (req_q.cmd == CMD_ACC) begin
			if (bad) res_d.status = ST_BADIDX;
			else if (oob_q) res_d.status = ST_OOB;
			else if (st.flat_beyond) res_d.status = ST_BEYOND;
			else begin
				res_d.bin_index = 12'(flat_q);
				res_d.bin_value = newv;
			end
		end else if (req_q.cmd != CMD_EDGE) begin
			res_d.bin_index = req_q.bin_select;
			if (st.sel_beyond) res_d.status = ST_BEYOND;
			else if (req_q.cmd == CMD_READ) res_d.bin_value = hist_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cm.edge_wr) edge_mem[req_q.edge_index] <= req_q.edge_value;
		edge_rd_q <= edge_mem[ed_addr];
		if (cm.sweep_wr) hist_mem[sweep_q] <= '0;
		else if (cm.hist_wr)
			hist_mem[hidx] <= (req_q.cmd == CMD_ACC) ? newv : 32'd0;
		if (cm.hist_rd) hist_rd_q <= hist_mem[hidx];
		if (cm.load) req_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			dim_q <= '0;
			base_q <= '0;
			lo_q <= '0;
			cnt_q <= '0;
			oob_q <= 1'b0;
			flat_q <= '0;
			res <= '0;
		end else begin
			if (cm.sweep_wr) sweep_q <= sweep_q + 1'b1;
			if (cm.load) begin
				dim_q <= '0;
				base_q <= '0;
				oob_q <= 1'b0;
				flat_q <= '0;
				lo_q <= '0;
				cnt_q <= '0;
			end
			if (cm.chk_eval) begin
				if (!cm.chk_last && $signed(edge_rd_q) > coord) oob_q <= 1'b1;
				if (cm.chk_last && $signed(edge_rd_q) < coord) oob_q <= 1'b1;
				if (!cm.chk_last && st.last_dim) begin
					dim_q <= '0;
					base_q <= '0;
					lo_q <= '0;
					cnt_q <= '0;
				end
			end
			if (cm.dim_next) begin
				dim_q <= dim_q + 2'd1;
				base_q <= base_q + {2'd0, n_cur};
			end
			if (cm.srch_eval) begin
				lo_q <= lo_q + 7'd1;
				if ($signed(edge_rd_q) <= coord) cnt_q <= cnt_q + 7'd1;
			end
			if (cm.dim_fold) begin
				flat_q <= 24'(flat_q * {17'd0, n_cur - 7'd1}) + {18'd0, bin};
				dim_q <= dim_q + 2'd1;
				base_q <= base_q + {2'd0, n_cur};
				lo_q <= '0;
				cnt_q <= '0;
			end
			if (cm.res_load) res <= res_d;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/multidim_histogram_binner_unit.sv
// Top level of the multidimensional histogram binner.
// Usage:
// One request channel (valid, stall, req) carries edge writes, samples,
// bin reads and bin clears; each request gives exactly one result on the
// result channel (res_valid, res_stall, res). Registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it.
// An edge write is stored at dispatch, then presents its result; a read or
// clear reads the histogram entry and, for a clear, writes it back as zero
// before the result. A sample takes dispatch, a bounds check per dimension,
// a scan per dimension counting the edges not above the coordinate, and the
// histogram read-modify-write and result; a bad layout ends after dispatch.
// One request is worked on at a time; the next is accepted no earlier than
// the edge where the result of the one before it is taken.
// After reset a clearing pass zeroes the histogram store, one bin a cycle;
// no request is accepted during it.
// A stalled result holds its value until taken and holds off new requests.
`default_nettype none
module multidim_histogram_binner_unit #(
	parameter int unsigned HIST_BINS = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire mhb_pkg::req_t req,
	output logic res_valid,
	input wire logic res_stall,
	output mhb_pkg::res_t res,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [6:0] cfg_data
);
	import mhb_pkg::*;

	cmd_t cm;
	stat_t st;
	logic [2:0] dims_q;
	logic [6:0] e0_q, e1_q, e2_q, e3_q;
	logic weighted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 3'd1;
			e0_q <= 7'd2;
			e1_q <= 7'd2;
			e2_q <= 7'd2;
			e3_q <= 7'd2;
			weighted_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS: dims_q <= cfg_data[2:0];
				REG_E0: e0_q <= cfg_data;
				REG_E1: e1_q <= cfg_data;
				REG_E2: e2_q <= cfg_data;
				REG_E3: e3_q <= cfg_data;
				REG_WEIGHTED: weighted_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mhb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_stall(req_stall),
		.out_valid(res_valid), .out_stall(res_stall),
		.cmd_in(req.cmd), .st(st), .cm(cm)
	);

	mhb_datapath #(.HIST_BINS(HIST_BINS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cm(cm), .st(st), .res(res),
		.dims_cfg(dims_q), .e0(e0_q), .e1(e1_q), .e2(e2_q), .e3(e3_q),
		.weighted(weighted_q)
	);
endmodule
`default_nettype wire

// File: tb/tb_multidim_histogram_binner_unit.sv
// Testbench for the multidimensional histogram binner: random and directed requests checked against a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_multidim_histogram_binner_unit;
	import mhb_pkg::*;

	localparam int NBINS = 4096;
	localparam logic [31:0] VMAX = 32'hFFFF_FFFF;

	class hist_scoreboard;
		logic [31:0] edge_mem [256];
		logic [31:0] counts [NBINS];
		logic [2:0] dims;
		logic [6:0] ecnt [4];
		bit wgt;
		res_t pending [$];
		int mismatches;
		int checked;

		function void clear_all();
			foreach (counts[i]) counts[i] = '0;
			dims = 3'd1;
			foreach (ecnt[i]) ecnt[i] = 7'd2;
			wgt = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [6:0] val);
			if (idx == REG_DIMS) dims = val[2:0];
			else if (idx >= REG_E0 && idx <= REG_E3) ecnt[idx - REG_E0] = val;
			else if (idx == REG_WEIGHTED) wgt = val[0];
		endfunction

		function res_t bin_sample(req_t r);
			res_t o;
			int nd, base, flat, cnt, bin, n;
			logic signed [31:0] c [4];
			logic [32:0] sum;
			bit inb;
			o = '0;
			nd = (dims < 1) ? 1 : (dims > 4) ? 4 : dims;
			c[0] = r.coord0; c[1] = r.coord1; c[2] = r.coord2; c[3] = r.coord3;
			base = 0;
			inb = 1;
			for (int d = 0; d < nd; d++) begin
				n = ecnt[d];
				if (n < 2 || n > 64 || base + n > 256) begin
					o.status = ST_BADIDX;
					return o;
				end
				if (c[d] < $signed(edge_mem[base]) || c[d] > $signed(edge_mem[base + n - 1]))
					inb = 0;
				base += n;
			end
			if (!inb) begin
				o.status = ST_OOB;
				return o;
			end
			base = 0;
			flat = 0;
			for (int d = 0; d < nd; d++) begin
				n = ecnt[d];
				cnt = 0;
				for (int k = 0; k < n; k++)
					if ($signed(edge_mem[base + k]) <= c[d]) cnt++;
				bin = (cnt == 0) ? 0 : cnt - 1;
				if (bin > n - 2) bin = n - 2;
				flat = flat * (n - 1) + bin;
				base += n;
			end
			if (flat >= NBINS) begin
				o.status = ST_BEYOND;
				return o;
			end
			sum = {1'b0, counts[flat]} + (wgt ? {1'b0, r.weight} : 33'd1);
			counts[flat] = sum[32] ? VMAX : sum[31:0];
			o.status = ST_DONE;
			o.bin_index = flat[11:0];
			o.bin_value = counts[flat];
			return o;
		endfunction

		function void note_request(req_t r);
			res_t o;
			o = '0;
			case (r.cmd)
				CMD_EDGE: edge_mem[r.edge_index] = r.edge_value;
				CMD_ACC: o = bin_sample(r);
				default: begin
					o.bin_index = r.bin_select;
					if (r.bin_select >= NBINS) o.status = ST_BEYOND;
					else if (r.cmd == CMD_READ) o.bin_value = counts[r.bin_select];
					else counts[r.bin_select] = '0;
				end
			endcase
			pending.push_back(o);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status || got.bin_index !== want.bin_index ||
					got.bin_value !== want.bin_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected st=%0d bin=%0d val=%0d, got st=%0d bin=%0d val=%0d",
						want.status, want.bin_index, want.bin_value,
						got.status, got.bin_index, got.bin_value);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 0;
	res_t res;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	hist_scoreboard sb;
	int gap_left = 0;
	int stall_mode = 0;
	int n_samples = 0;
	int n_phases = 0;

	multidim_histogram_binner_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (res_valid && !res_stall) sb.check_result(res);
		case (stall_mode)
			0: res_stall <= 0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: res_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	initial begin
		#200_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send(req_t r);
		@(posedge clk);
		while (gap_left > 0) begin
			gap_left--;
			@(posedge clk);
		end
		req <= r;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(r);
		if (r.cmd == CMD_ACC) n_samples++;
		req_valid <= 0;
		if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(0, 12);
	endtask

	task automatic drain();
		@(posedge clk);
		req_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [6:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic req_t rand_req();
		req_t r;
		r.cmd = 2'($urandom);
		r.edge_index = 8'($urandom);
		r.edge_value = $urandom;
		r.coord0 = $urandom;
		r.coord1 = $urandom;
		r.coord2 = $urandom;
		r.coord3 = $urandom;
		r.weight = $urandom;
		r.bin_select = 12'($urandom);
		return r;
	endfunction

	task automatic write_edges(int total);
		req_t r;
		int v;
		v = -2147483648 + $urandom_range(0, 1000);
		for (int i = 0; i < total; i++) begin
			r = rand_req();
			r.cmd = CMD_EDGE;
			r.edge_index = i[7:0];
			r.edge_value = v;
			send(r);
			v = ($urandom_range(0, 3) == 0) ? v + $urandom_range(0, 3) :
				v + $urandom_range(1, 60000000);
		end
	endtask

	function automatic logic signed [31:0] pick_coord(int base, int n);
		logic signed [31:0] lo, hi;
		lo = sb.edge_mem[base];
		hi = sb.edge_mem[base + n - 1];
		case ($urandom_range(0, 9))
			0: return lo;
			1: return hi;
			2: return sb.edge_mem[base + $urandom_range(0, n - 1)];
			3: return $urandom;
			default: return lo + $signed(32'($urandom % (64'(hi - lo) + 1)));
		endcase
	endfunction

	task automatic run_phase(int nitems);
		req_t r;
		int base [4];
		int total;
		total = 0;
		for (int d = 0; d < 4; d++) begin
			base[d] = total;
			total += sb.ecnt[d];
		end
		write_edges(total);
		for (int i = 0; i < nitems; i++) begin
			r = rand_req();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					r.cmd = CMD_ACC;
					r.coord0 = pick_coord(base[0], sb.ecnt[0]);
					r.coord1 = pick_coord(base[1], sb.ecnt[1]);
					r.coord2 = pick_coord(base[2], sb.ecnt[2]);
					r.coord3 = pick_coord(base[3], sb.ecnt[3]);
					if ($urandom_range(0, 9) == 0) r.weight = VMAX - $urandom_range(0, 3);
				end
				6, 7: begin
					r.cmd = ($urandom_range(0, 1)) ? CMD_READ : CMD_CLEAR;
					if ($urandom_range(0, 3) != 0) r.bin_select = 12'($urandom_range(0, 63));
				end
				default: begin
					r.cmd = CMD_EDGE;
					r.edge_index = 8'($urandom_range(0, total - 1));
					r.edge_value = sb.edge_mem[r.edge_index];
					if ($urandom_range(0, 3) == 0) r.edge_value = $urandom;
				end
			endcase
			send(r);
		end
		drain();
		n_phases++;
	endtask

	task automatic configure(int nd, int e0, int e1, int e2, int e3, bit w);
		set_reg(REG_DIMS, 7'(nd));
		set_reg(REG_E0, 7'(e0));
		set_reg(REG_E1, 7'(e1));
		set_reg(REG_E2, 7'(e2));
		set_reg(REG_E3, 7'(e3));
		set_reg(REG_WEIGHTED, 7'(w));
	endtask

	initial begin
		req_t r;
		sb = new();
		sb.clear_all();
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed part, under reset settings and then in weighted mode: edges, extremes, saturation and edge cases.
		write_edges(2);
		r = '0;
		r.cmd = CMD_ACC;
		r.coord0 = sb.edge_mem[0];
		send(r);
		r.coord0 = sb.edge_mem[1];
		send(r);
		r.coord0 = 32'sh8000_0000;
		send(r);
		r.coord0 = 32'sh7FFF_FFFF;
		send(r);
		r.cmd = CMD_READ;
		r.bin_select = 12'd0;
		send(r);
		r.bin_select = 12'hFFF;
		send(r);
		r.cmd = CMD_CLEAR;
		send(r);
		r.bin_select = 12'd0;
		send(r);
		r = '0;
		r.cmd = CMD_EDGE;
		r.edge_index = 8'hFF;
		r.edge_value = 32'sh7FFF_FFFF;
		send(r);
		r.edge_index = 8'd0;
		r.edge_value = 32'sh8000_0000;
		send(r);
		r.edge_index = 8'd1;
		r.edge_value = 32'sh7FFF_FFFF;
		send(r);
		drain();
		set_reg(REG_WEIGHTED, 7'd1);
		r = '0;
		r.cmd = CMD_ACC;
		r.coord0 = 32'sh7FFF_FFFF;
		r.weight = VMAX;
		send(r);
		send(r);
		r.weight = 32'd0;
		send(r);
		drain();
		// Bad layouts: counts below two and above the limit, then a layout that fills the store exactly.
		set_reg(REG_E0, 7'd1);
		r.cmd = CMD_ACC;
		send(r);
		drain();
		set_reg(REG_E0, 7'd127);
		send(r);
		drain();
		set_reg(REG_E0, 7'd65);
		send(r);
		drain();
		configure(4, 64, 64, 64, 64, 0);
		send(r);
		drain();

		configure(1, 64, 2, 2, 2, 0);
		run_phase(120);
		configure(4, 64, 64, 64, 63, 1);
		write_edges(255);
		drain();
		configure(0, 3, 2, 2, 2, 1);
		run_phase(100);
		configure(2, 64, 64, 2, 2, 0);
		run_phase(150);
		stall_mode = 2;
		configure(7, 2, 2, 2, 2, 1);
		run_phase(100);
		stall_mode = 1;
		configure(4, 9, 9, 9, 9, 0);
		run_phase(200);
		configure(3, 17, 17, 17, 2, 1);
		run_phase(150);
		configure(2, 2, 64, 5, 5, 0);
		run_phase(150);

		$display("covered %0d phases, %0d samples binned, %0d results checked",
			n_phases, n_samples, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
